// ===== hw/rtl/snt_pkg.sv =====
// Package for the sphere normal to texel block: payload types, CORDIC table,
// fixed-point constants. No dependencies.
`default_nettype none
package snt_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int DIM_BITS     = 12;
    localparam int CORDIC_STEPS = 28;
    localparam int PRESHIFT     = 24;
    localparam int ANG_W        = 32;   // angle, pi = 2^30
    localparam int CW           = 44;   // CORDIC datapath width, signed
    localparam int SQ_W         = 30;   // radicand width (< 2^29 plus margin)
    localparam int RT_W         = 15;   // root width
    localparam logic signed [ANG_W-1:0] ANG_PI = 32'sd1073741824;

    localparam logic [1:0] ST_TEXEL = 2'd0;
    localparam logic [1:0] ST_POLE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    typedef struct packed {
        logic               has_object;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } snt_in_t;

    typedef struct packed {
        logic [11:0] texel_column;
        logic [11:0] texel_row;
        logic [1:0]  status;
    } snt_out_t;

    // Per-item side information carried along the pipeline.
    typedef struct packed {
        logic [1:0] status;
        logic       lon_fixed;   // ratio out of range: longitude angle forced
        logic       lon_pi;      // forced value is pi (else 0)
        logic       nz_pos;
    } snt_side_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] v;
        begin
            case (i)
                0:  v = 32'sd268435456;
                1:  v = 32'sd158466703;
                2:  v = 32'sd83729453;
                3:  v = 32'sd42502378;
                4:  v = 32'sd21333665;
                5:  v = 32'sd10677232;
                6:  v = 32'sd5339919;
                7:  v = 32'sd2670122;
                8:  v = 32'sd1335081;
                9:  v = 32'sd667543;
                10: v = 32'sd333772;
                11: v = 32'sd166886;
                12: v = 32'sd83443;
                13: v = 32'sd41721;
                14: v = 32'sd20860;
                15: v = 32'sd10430;
                16: v = 32'sd5215;
                17: v = 32'sd2607;
                18: v = 32'sd1303;
                19: v = 32'sd651;
                20: v = 32'sd325;
                21: v = 32'sd162;
                22: v = 32'sd81;
                23: v = 32'sd40;
                24: v = 32'sd20;
                25: v = 32'sd10;
                26: v = 32'sd5;
                27: v = 32'sd2;
                default: v = '0;
            endcase
            atan_entry = v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sphere_normal_to_texel.sv =====
// Sphere normal to texel: spherical UV lookup of a unit normal.
// Pipeline stages: 1 front, 15 root, 29 CORDIC, 1 longitude select, 1 scale,
// 1 wrap and output.
// Throughput: one item per cycle; busy is held low, the pipeline never stalls
// because the receiver cannot hold results off.
// Reset: valid bits clear; image size returns to 1024 x 512.
`default_nettype none
module sphere_normal_to_texel (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire snt_pkg::snt_in_t   in_item,
    output logic                    done,
    output snt_pkg::snt_out_t       out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [12:0]        cfg_data
);
    import snt_pkg::*;

    localparam int SQ_LAT = RT_W;               // root stages
    localparam int CD_LAT = CORDIC_STEPS + 1;   // CORDIC stages
    localparam int MID    = SQ_LAT + CD_LAT;    // delay after front stage

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [12:0] cols_reg, rows_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cols_reg <= 13'd1024;
            rows_reg <= 13'd512;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COLUMNS: cols_reg <= cfg_data;
                REG_ROWS:    rows_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ---- Front stage: clamp ny, classify, form both radicands ----
    // Squares are formed at full width: nx = -2^15 squares to 2^30.
    localparam logic signed [16:0] ONE = 17'sd16384;
    logic signed [16:0] nx, ny_c;
    logic signed [33:0] ny_sq, nx_sq;
    logic [SQ_W-1:0] s2, t;
    logic signed [33:0] t_s;
    logic bad_size;
    snt_side_t side_next;
    always_comb
    begin
        nx = 17'(in_item.normal_x);
        ny_c = 17'(in_item.normal_y);
        if (ny_c > ONE) ny_c = ONE;
        if (ny_c < -ONE) ny_c = -ONE;
        ny_sq = ny_c * ny_c;
        nx_sq = nx * nx;
        s2 = SQ_W'(34'sd268435456 - ny_sq);
        t_s = $signed({4'b0, s2}) - nx_sq;
        t = (t_s > 0) ? SQ_W'(t_s) : '0;
        bad_size = (cols_reg == 13'd0) || (rows_reg == 13'd0) ||
                   (cols_reg > 13'd4096) || (rows_reg > 13'd4096);
        side_next.status = (!in_item.has_object || bad_size) ? ST_ERROR :
                           ((ny_c == ONE || ny_c == -ONE) ? ST_POLE : ST_TEXEL);
        side_next.lon_fixed = (t_s <= 0);
        side_next.lon_pi = !(nx < 0);
        side_next.nz_pos = in_item.normal_z > 0;
    end

    logic [SQ_W-1:0] s2_reg, t_reg;
    logic signed [16:0] nlat_reg, nlon_reg;
    snt_side_t side_reg;
    logic v0_reg;
    always_ff @(posedge clk)
    begin
        s2_reg <= s2;
        t_reg <= t;
        nlat_reg <= -ny_c;
        nlon_reg <= -nx;
        side_reg <= side_next;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v0_reg <= 1'b0;
        else        v0_reg <= start;
    end

    // ---- Square roots ----
    logic [SQ_W-1:0] r_lat, r_lon;
    snt_isqrt u_sq_lat (.clk, .rst_n, .in_valid(v0_reg), .radicand(s2_reg), .root(r_lat));
    snt_isqrt u_sq_lon (.clk, .rst_n, .in_valid(v0_reg), .radicand(t_reg), .root(r_lon));

    // x operands delayed to line up with the roots
    logic signed [16:0] xl_d [SQ_LAT];
    logic signed [16:0] xn_d [SQ_LAT];
    always_ff @(posedge clk)
    begin
        xl_d[0] <= nlat_reg;
        xn_d[0] <= nlon_reg;
        for (int k = 1; k < SQ_LAT; k++) begin
            xl_d[k] <= xl_d[k-1];
            xn_d[k] <= xn_d[k-1];
        end
    end

    logic [ANG_W-1:0] zlat, zlon_c;
    snt_cordic u_cd_lat (.clk, .x_in(xl_d[SQ_LAT-1]), .y_in(r_lat[RT_W-1:0]), .angle(zlat));
    snt_cordic u_cd_lon (.clk, .x_in(xn_d[SQ_LAT-1]), .y_in(r_lon[RT_W-1:0]),
                         .angle(zlon_c));

    // side info and valid delay line
    snt_side_t side_d [MID];
    logic [MID-1:0] v_d_reg;
    always_ff @(posedge clk)
    begin
        side_d[0] <= side_reg;
        for (int k = 1; k < MID; k++) side_d[k] <= side_d[k-1];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_d_reg <= '0;
        else        v_d_reg <= {v_d_reg[MID-2:0], v0_reg};
    end

    // ---- Longitude select ----
    snt_side_t sd;
    assign sd = side_d[MID-1];
    logic [ANG_W-1:0] zlon, lon_next;
    always_comb
    begin
        zlon = sd.lon_fixed ? (sd.lon_pi ? ANG_W'(ANG_PI) : '0) : zlon_c;
        lon_next = sd.nz_pos ? zlon : ANG_W'(2 * ANG_PI) - zlon;
    end

    logic [ANG_W-1:0] lon_reg, lat_reg;
    snt_side_t s1_reg;
    logic v1_reg;
    always_ff @(posedge clk)
    begin
        lon_reg <= lon_next;
        lat_reg <= zlat;
        s1_reg <= sd;
    end

    // ---- Scale by image size ----
    logic [44:0] pc_reg, pr_reg;
    snt_side_t s2s_reg;
    logic v2_reg;
    always_ff @(posedge clk)
    begin
        pc_reg <= lon_reg * cols_reg;
        pr_reg <= lat_reg * rows_reg;
        s2s_reg <= s1_reg;
    end

    // ---- Wrap / saturate and output ----
    logic [13:0] col_n, row_n;
    snt_out_t out_next;
    always_comb
    begin
        col_n = 14'(cols_reg) - 14'(pc_reg >> 31);
        if (col_n >= 14'(cols_reg)) col_n = '0;
        row_n = 14'(pr_reg >> 30);
        if (row_n >= 14'(rows_reg)) row_n = 14'(rows_reg) - 14'd1;
        out_next.status = s2s_reg.status;
        if (s2s_reg.status == ST_TEXEL) begin
            out_next.texel_column = col_n[11:0];
            out_next.texel_row = row_n[11:0];
        end else begin
            out_next.texel_column = '0;
            out_next.texel_row = '0;
        end
    end

    logic done_reg;
    snt_out_t out_reg;
    always_ff @(posedge clk)
        out_reg <= out_next;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg <= v_d_reg[MID-1];
            v2_reg <= v1_reg;
            done_reg <= v2_reg;
        end
    end
    assign done = done_reg;
    assign out_item = out_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/snt_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on snt_pkg.
`default_nettype none
module snt_isqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [snt_pkg::SQ_W-1:0]  radicand,
    output logic [snt_pkg::SQ_W-1:0]       root
);
    import snt_pkg::*;
    localparam int NS = RT_W;

    logic [SQ_W-1:0] rem_reg [NS+1];
    logic [SQ_W-1:0] res_reg [NS+1];

    assign rem_reg[0] = radicand;
    assign res_reg[0] = '0;

    for (genvar k = 0; k < NS; k++) begin : g_st
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (NS - 1 - k));
        logic [SQ_W-1:0] rem_next, res_next;
        logic [SQ_W-1:0] rem_q, res_q;
        always_comb
        begin
            if (rem_reg[k] >= res_reg[k] + BIT) begin
                rem_next = rem_reg[k] - (res_reg[k] + BIT);
                res_next = (res_reg[k] >> 1) + BIT;
            end else begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end
        always_ff @(posedge clk)
        begin
            rem_q <= rem_next;
            res_q <= res_next;
        end
        assign rem_reg[k+1] = rem_q;
        assign res_reg[k+1] = res_q;
    end

    assign root = res_reg[NS];

    logic unused_ok;
    assign unused_ok = in_valid & rst_n;
endmodule
`default_nettype wire

// ===== hw/rtl/snt_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (x, y), y >= 0, pi = 2^30, clamped.
// One iteration per stage. Depends on snt_pkg.
`default_nettype none
module snt_cordic (
    input  wire logic                          clk,
    input  wire logic signed [16:0]            x_in,
    input  wire logic [snt_pkg::RT_W-1:0]      y_in,
    output logic [snt_pkg::ANG_W-1:0]          angle
);
    import snt_pkg::*;

    logic signed [CW-1:0]    x_s [CORDIC_STEPS+2];
    logic signed [CW-1:0]    y_s [CORDIC_STEPS+2];
    logic signed [ANG_W-1:0] z_s [CORDIC_STEPS+2];

    // Pre-rotation and preshift stage
    logic signed [CW-1:0] x0_reg, y0_reg;
    logic signed [ANG_W-1:0] z0_reg;
    always_ff @(posedge clk)
    begin
        if (x_in < 0) begin
            x0_reg <= CW'($signed({1'b0, y_in})) <<< PRESHIFT;
            y0_reg <= (-CW'(x_in)) <<< PRESHIFT;
            z0_reg <= ANG_PI >>> 1;
        end else begin
            x0_reg <= CW'(x_in) <<< PRESHIFT;
            y0_reg <= CW'($signed({1'b0, y_in})) <<< PRESHIFT;
            z0_reg <= '0;
        end
    end
    assign x_s[0] = x0_reg;
    assign y_s[0] = y0_reg;
    assign z_s[0] = z0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
        localparam logic signed [ANG_W-1:0] AT = atan_entry(i);
        logic signed [CW-1:0] xq, yq;
        logic signed [ANG_W-1:0] zq;
        always_ff @(posedge clk)
        begin
            if (y_s[i] > 0) begin
                xq <= x_s[i] + (y_s[i] >>> i);
                yq <= y_s[i] - (x_s[i] >>> i);
                zq <= z_s[i] + AT;
            end else begin
                xq <= x_s[i] - (y_s[i] >>> i);
                yq <= y_s[i] + (x_s[i] >>> i);
                zq <= z_s[i] - AT;
            end
        end
        assign x_s[i+1] = xq;
        assign y_s[i+1] = yq;
        assign z_s[i+1] = zq;
    end
    assign x_s[CORDIC_STEPS+1] = '0;
    assign y_s[CORDIC_STEPS+1] = '0;
    assign z_s[CORDIC_STEPS+1] = '0;

    logic signed [ANG_W-1:0] zf;
    assign zf = z_s[CORDIC_STEPS];
    always_comb
    begin
        if (zf < 0)
            angle = '0;
        else if (zf > ANG_PI)
            angle = ANG_PI;
        else
            angle = zf;
    end

    logic unused_ok;
    assign unused_ok = ^{x_s[CORDIC_STEPS], y_s[CORDIC_STEPS], x_s[CORDIC_STEPS+1],
                         y_s[CORDIC_STEPS+1], z_s[CORDIC_STEPS+1]};
endmodule
`default_nettype wire

// ===== hw/rtl/snt_checker.sv =====
// Port-level checks for sphere_normal_to_texel, bound to the top level.
// Depends on snt_pkg.
`default_nettype none
module snt_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              done,
    input wire logic              busy,
    input wire snt_pkg::snt_out_t out_item
);
    import snt_pkg::*;

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_item.status == ST_TEXEL || out_item.status == ST_POLE ||
                  out_item.status == ST_ERROR)) else $error("bad status");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_item.status != ST_TEXEL) |->
        (out_item.texel_column == 12'd0 && out_item.texel_row == 12'd0))
        else $error("nonzero texel on pole or error");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
endmodule

bind sphere_normal_to_texel snt_checker u_snt_checker (
    .clk, .rst_n, .done, .busy, .out_item);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for sphere_normal_to_texel: drives mostly unit normals, predicts texels
// with a bit-exact fixed-point mapping, checks each strobed result in order.
// Depends on snt_pkg and the sphere_normal_to_texel RTL.
`timescale 1ns / 1ps

class texel_scoreboard;
    snt_pkg::snt_out_t pending[$];
    int mismatches;
    int checked;
    logic [12:0] columns;
    logic [12:0] rows;

    function new();
        mismatches = 0;
        checked = 0;
        columns = 13'd1024;
        rows = 13'd512;
    endfunction

    // floor shift of a signed value
    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint root(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC: atan2(y, x) for y >= 0, pi = 2^30
    function automatic longint angle(longint x, longint y);
        longint z;
        longint tx;
        longint dx;
        longint dy;
        longint tab[28];
        tab = '{268435456, 158466703, 83729453, 42502378, 21333665, 10677232,
                5339919, 2670122, 1335081, 667543, 333772, 166886, 83443, 41721,
                20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20, 10, 5, 2};
        z = 0;
        if (x < 0)
        begin
            tx = y;
            y = -x;
            x = tx;
            z = 64'sd1 <<< 29;
        end
        x = x <<< 24;
        y = y <<< 24;
        for (int i = 0; i < 28; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + tab[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - tab[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > (64'sd1 <<< 30))
            z = 64'sd1 <<< 30;
        return z;
    endfunction

    function automatic snt_pkg::snt_out_t map_texel(snt_pkg::snt_in_t n);
        snt_pkg::snt_out_t r;
        longint one;
        longint nx;
        longint ny;
        longint nz;
        longint s2;
        longint t;
        longint zlat;
        longint zlon;
        longint lon;
        longint col;
        longint row;
        one = 64'sd1 <<< 14;
        r = '0;
        if (!n.has_object || columns == 0 || rows == 0 || columns > 4096 || rows > 4096)
        begin
            r.status = snt_pkg::ST_ERROR;
            return r;
        end
        nx = n.normal_x;
        ny = n.normal_y;
        nz = n.normal_z;
        if (ny > one)
            ny = one;
        if (ny < -one)
            ny = -one;
        if (ny == one || ny == -one)
        begin
            r.status = snt_pkg::ST_POLE;
            return r;
        end
        s2 = one * one - ny * ny;
        zlat = angle(-ny, root(s2));
        t = s2 - nx * nx;
        if (t <= 0)
            zlon = (-nx > 0) ? 0 : (64'sd1 <<< 30);
        else
            zlon = angle(-nx, root(t));
        lon = (nz > 0) ? zlon : (64'sd1 <<< 31) - zlon;
        col = columns - ((lon * columns) >>> 31);
        if (col >= columns)
            col = 0;
        row = (zlat * rows) >>> 30;
        if (row >= rows)
            row = rows - 1;
        r.texel_column = col[11:0];
        r.texel_row = row[11:0];
        r.status = snt_pkg::ST_TEXEL;
        return r;
    endfunction

    function void note_item(snt_pkg::snt_in_t n);
        pending.push_back(map_texel(n));
    endfunction

    function void check_texel(snt_pkg::snt_out_t got);
        snt_pkg::snt_out_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result col=%0d row=%0d st=%0d",
                         got.texel_column, got.texel_row, got.status);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.texel_column !== want.texel_column || got.texel_row !== want.texel_row
            || got.status !== want.status)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: want col=%0d row=%0d st=%0d, got col=%0d row=%0d st=%0d",
                         want.texel_column, want.texel_row, want.status,
                         got.texel_column, got.texel_row, got.status);
        end
    endfunction
endclass

module tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    snt_pkg::snt_in_t in_item = '0;
    logic done;
    snt_pkg::snt_out_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [12:0] cfg_data = '0;

    texel_scoreboard texels = new();
    int sent = 0;

    always #10 clk = ~clk;

    sphere_normal_to_texel dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .out_item(out_item), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Results cannot be held off: sample on every edge where done is high.
    always @(posedge clk)
        if (rst_n && done)
            texels.check_texel(out_item);

    // Register write while the pipeline is empty; the model updates with it.
    task automatic write_size(logic idx, logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == snt_pkg::REG_COLUMNS)
            texels.columns = value;
        else
            texels.rows = value;
        @(posedge clk);
    endtask

    // One item, with a random gap before it when gaps are on.
    // start stays high between back-to-back items; drain() drops it.
    task automatic send_normal(snt_pkg::snt_in_t n, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_item <= n;
        do @(posedge clk); while (busy);
        texels.note_item(n);
        sent++;
    endtask

    // Wait for all outstanding results, then let the pipe drain.
    task automatic drain();
        start <= 1'b0;
        while (texels.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rnd_comp();
        case ($urandom_range(0, 5))
            0: return 16'(signed'($urandom_range(0, 32768)) - 16384);
            1: return 16'($urandom);
            2: return 16'sd16384;
            3: return -16'sd16384;
            default: return 16'(signed'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // Random normal, mostly near unit length, sometimes raw noise.
    function automatic snt_pkg::snt_in_t rnd_normal();
        snt_pkg::snt_in_t n;
        real a;
        real b;
        n.has_object = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0)
        begin
            n.normal_x = rnd_comp();
            n.normal_y = rnd_comp();
            n.normal_z = rnd_comp();
        end
        else
        begin
            a = $urandom_range(0, 62831) / 10000.0;
            b = ($urandom_range(0, 20000) / 10000.0) - 1.0;
            n.normal_y = 16'($rtoi(b * 16384.0));
            n.normal_x = 16'($rtoi($cos(a) * $sqrt(1.0 - b * b) * 16384.0));
            n.normal_z = 16'($rtoi($sin(a) * $sqrt(1.0 - b * b) * 16384.0));
        end
        return n;
    endfunction

    task automatic directed();
        snt_pkg::snt_in_t n;
        n = '{1'b0, 16'sd0, 16'sd0, 16'sd16384};
        send_normal(n, 0);  // nothing hit
        n = '{1'b1, 16'sd0, 16'sd16384, 16'sd0};
        send_normal(n, 0);  // north pole
        n = '{1'b1, 16'sd0, -16'sd16384, 16'sd0};
        send_normal(n, 0);  // south pole
        n = '{1'b1, 16'sd0, 16'sh7fff, 16'sd0};
        send_normal(n, 0);  // y clamped to pole
        n = '{1'b1, 16'sd0, 16'sh8000, 16'sd0};
        send_normal(n, 0);
        n = '{1'b1, 16'sd16384, 16'sd0, 16'sd0};
        send_normal(n, 0);  // ratio at +1
        n = '{1'b1, -16'sd16384, 16'sd0, 16'sd0};
        send_normal(n, 0);  // ratio at -1
        n = '{1'b1, 16'sh7fff, 16'sd100, 16'sh8000};
        send_normal(n, 0);  // ratio beyond range
        n = '{1'b1, 16'sh8000, 16'sd100, 16'sh7fff};
        send_normal(n, 0);
        n = '{1'b1, 16'sd0, 16'sd0, 16'sd16384};
        send_normal(n, 0);
        n = '{1'b1, 16'sd0, 16'sd0, -16'sd16384};
        send_normal(n, 0);  // nz not positive
        n = '{1'b1, 16'sd0, 16'sd0, 16'sd0};
        send_normal(n, 0);
        n = '{1'b1, 16'sd11585, 16'sd0, 16'sd11585};
        send_normal(n, 0);
        n = '{1'b1, 16'sd1, 16'sd16383, -16'sd1};
        send_normal(n, 0);  // near pole
        n = '{1'b1, -16'sd1, -16'sd16383, 16'sd1};
        send_normal(n, 0);
    endtask

    initial
    begin
        logic [12:0] col_set[6];
        logic [12:0] row_set[6];
        col_set = '{13'd1024, 13'd1, 13'd4096, 13'd0, 13'd4097, 13'd640};
        row_set = '{13'd512, 13'd4096, 13'd1, 13'd300, 13'd8191, 13'd4096};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_size(snt_pkg::REG_COLUMNS, col_set[ph]);
            write_size(snt_pkg::REG_ROWS, row_set[ph]);
            directed();
            for (int k = 0; k < 330; k++)
                send_normal(rnd_normal(), (k / 60) % 2 == 0);
            drain();
        end
        write_size(snt_pkg::REG_COLUMNS, 13'($urandom_range(1, 4096)));
        write_size(snt_pkg::REG_ROWS, 13'($urandom_range(1, 4096)));
        for (int k = 0; k < 100; k++)
            send_normal(rnd_normal(), 1);
        drain();
        $display("covered %0d items over 7 image sizes, %0d results checked",
                 sent, texels.checked);
        $display("including poles, misses, bad sizes and out-of-range ratios");
        if (texels.mismatches == 0 && texels.pending.size() == 0)
            $display("PASS sphere_normal_to_texel");
        else
            $display("FAIL sphere_normal_to_texel");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL sphere_normal_to_texel");
        $finish;
    end
endmodule
